FILE: sv/tfd_pkg.sv
// tfd_pkg: shared constants, types and helpers for the tracker frame deframer.
// No dependencies; imported by tfd_pose_ram, tracker_frame_deframer and tb_tracker_frame_deframer.
package tfd_pkg;

  // default geometry of a frame
  localparam int unsigned CHANNELS_DEF      = 5;
  localparam int unsigned AXES_DEF          = 6;
  localparam int unsigned PAYLOAD_BYTES_DEF = 196;

  // fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CH_W   = 3;
  localparam int unsigned AX_W   = 3;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned POSE_W = 32;

  // framing bytes
  localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'hA5;
  localparam logic [BYTE_W-1:0] HDR_SECOND  = 8'h5A;
  localparam logic [BYTE_W-1:0] TAIL_FIRST  = 8'hB6;
  localparam logic [BYTE_W-1:0] TAIL_SECOND = 8'h6B;
  localparam int unsigned       ID_LEN      = 4;

  // pose layout inside the payload: channel c starts at POSE_BASE + STRIDE*c
  localparam int unsigned POSE_BASE   = 38;
  localparam int unsigned STRIDE      = 26;
  localparam int unsigned SUB_W       = 5;
  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned ASM_W       = (WORD_BYTES - 1) * BYTE_W;

  // channel_mode code that selects every channel
  localparam logic [MODE_W-1:0] MODE_ALL = 3'd5;

  typedef enum logic [2:0] {
    S_HUNT,
    S_HDR2,
    S_ID,
    S_PAYLOAD,
    S_EMIT
  } parse_state_e;

  // expected ID byte at each position
  function automatic logic [BYTE_W-1:0] id_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      2'd0:    b = 8'h02;
      2'd1:    b = 8'h02;
      2'd2:    b = 8'h00;
      default: b = 8'hC0;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/tfd_pose_ram.sv
// tfd_pose_ram: pose word store, one write port and one registered read port.
// Depends on tfd_pkg for the word width and the default depth.
module tfd_pose_ram
  import tfd_pkg::*;
#(
  parameter int unsigned DEPTH = CHANNELS_DEF * AXES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [POSE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [POSE_W-1:0] rdata_o
);

  logic [POSE_W-1:0] mem_q [DEPTH];
  logic [POSE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tracker_frame_deframer.sv
// tracker_frame_deframer: top level of the position-tracker frame deframer.
// Depends on tfd_pkg and tfd_pose_ram.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
//   byte per request. The parser hunts for A5 5A, checks the ID bytes
//   02 02 00 C0, then counts PAYLOAD_BYTES payload bytes and writes the pose
//   words into a CHANNELS*AXES word RAM as their fourth byte arrives.
//   Output channel (out_valid_o / out_ready_i) carries one pose word per
//   request with its channel, axis and a last_of_run flag.
//   Throughput: one byte per cycle while parsing. After a good tail with a
//   channel selected, the input stalls for the readout, one RAM read per
//   cycle while the receiver takes words: AXES words for one channel,
//   CHANNELS*AXES for all. The first word shows once the readout state and
//   then the RAM read register are loaded; the last word waits in the
//   output register while input bytes are already taken again.
//   A bad header, ID or tail produces nothing and hunting resumes.
//   cfg_we_i / cfg_wdata_i load channel_mode (0..4 one channel, 5 all).
//   Reset: parser hunting, channel_mode 0, output empty. The RAM is not
//   cleared; every word read out was written by the same frame.
module tracker_frame_deframer
  import tfd_pkg::*;
#(
  parameter int unsigned CHANNELS      = CHANNELS_DEF,
  parameter int unsigned AXES          = AXES_DEF,
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [MODE_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [BYTE_W-1:0]        rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CH_W-1:0]          channel_o,
  output logic [AX_W-1:0]          axis_o,
  output logic signed [POSE_W-1:0] pose_value_o,
  output logic                     last_of_run_o
);

  localparam int unsigned DEPTH     = CHANNELS * AXES;
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW        = $clog2(PAYLOAD_BYTES);
  localparam int unsigned WORD_SPAN = WORD_BYTES * AXES;

  parse_state_e state_q, state_d;

  logic [CW-1:0]     byte_cnt_q;
  logic [1:0]        id_cnt_q;
  logic              id_bad_q;
  logic              tail_seen_q;
  logic [SUB_W-1:0]  sub_q;
  logic [CH_W-1:0]   pch_q;
  logic [AW-1:0]     wa_q;
  logic [ASM_W-1:0]  asm_q;
  logic [MODE_W-1:0] mode_q;
  logic [AW-1:0]     rd_addr_q;
  logic [CH_W-1:0]   rd_ch_q;
  logic [AX_W-1:0]   rd_ax_q;
  logic [CH_W-1:0]   last_ch_q;
  logic              out_valid_q;
  logic [CH_W-1:0]   out_ch_q;
  logic [AX_W-1:0]   out_ax_q;
  logic              out_last_q;

  logic              in_fire;
  logic              id_last, id_miss;
  logic              pay_last, tail_ok;
  logic              mode_all, mode_one, emit_any;
  logic [CH_W-1:0]   first_ch, last_ch;
  logic              pose_on, in_word;
  logic [1:0]        lane;
  logic              ram_we;
  logic [POSE_W-1:0] ram_wdata, ram_rdata;
  logic              rd_issue, rd_last;

  assign in_ready_o = (state_q != S_EMIT);
  assign in_fire    = in_valid_i && in_ready_o;

  assign id_last  = (id_cnt_q == 2'(ID_LEN - 1));
  assign id_miss  = (rx_byte_i != id_byte(id_cnt_q));
  assign pay_last = (byte_cnt_q == CW'(PAYLOAD_BYTES - 1));
  assign tail_ok  = tail_seen_q && (rx_byte_i == TAIL_SECOND);

  assign mode_all = (mode_q == MODE_ALL);
  assign mode_one = (mode_q < CH_W'(CHANNELS));
  assign emit_any = mode_all || mode_one;
  assign first_ch = mode_all ? '0 : mode_q;
  assign last_ch  = mode_all ? CH_W'(CHANNELS - 1) : mode_q;

  // pose region walk: sub_q is the offset inside the current channel stride
  assign pose_on   = (byte_cnt_q >= CW'(POSE_BASE)) && (pch_q < CH_W'(CHANNELS));
  assign in_word   = (sub_q < SUB_W'(WORD_SPAN));
  assign lane      = sub_q[1:0];
  assign ram_we    = in_fire && (state_q == S_PAYLOAD) && pose_on && in_word && (lane == 2'd3);
  assign ram_wdata = {rx_byte_i, asm_q};

  assign rd_issue = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign rd_last  = (rd_ch_q == last_ch_q) && (rd_ax_q == AX_W'(AXES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_HUNT: begin
        if (in_fire && rx_byte_i == HDR_FIRST) state_d = S_HDR2;
      end
      S_HDR2: begin
        if (in_fire) state_d = (rx_byte_i == HDR_SECOND) ? S_ID : S_HUNT;
      end
      S_ID: begin
        if (in_fire && id_last) state_d = (id_bad_q || id_miss) ? S_HUNT : S_PAYLOAD;
      end
      S_PAYLOAD: begin
        if (in_fire && pay_last) state_d = (tail_ok && emit_any) ? S_EMIT : S_HUNT;
      end
      S_EMIT: begin
        if (rd_issue && rd_last) state_d = S_HUNT;
      end
      default: state_d = S_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q  <= '0;
      id_cnt_q    <= '0;
      id_bad_q    <= 1'b0;
      tail_seen_q <= 1'b0;
      sub_q       <= '0;
      pch_q       <= '0;
      wa_q        <= '0;
      mode_q      <= '0;
      rd_addr_q   <= '0;
      rd_ch_q     <= '0;
      rd_ax_q     <= '0;
      last_ch_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        unique case (state_q)
          S_HDR2: begin
            if (rx_byte_i == HDR_SECOND) begin
              id_cnt_q <= '0;
              id_bad_q <= 1'b0;
            end
          end
          S_ID: begin
            id_bad_q <= id_bad_q || id_miss;
            id_cnt_q <= id_cnt_q + 2'd1;
            if (id_last) begin
              byte_cnt_q  <= '0;
              tail_seen_q <= 1'b0;
              sub_q       <= '0;
              pch_q       <= '0;
              wa_q        <= '0;
            end
          end
          S_PAYLOAD: begin
            if (byte_cnt_q == CW'(PAYLOAD_BYTES - 2)) begin
              tail_seen_q <= (rx_byte_i == TAIL_FIRST);
            end
            if (pay_last) begin
              byte_cnt_q  <= '0;
              tail_seen_q <= 1'b0;
              rd_addr_q   <= AW'(first_ch * AXES);
              rd_ch_q     <= first_ch;
              rd_ax_q     <= '0;
              last_ch_q   <= last_ch;
            end else begin
              byte_cnt_q <= byte_cnt_q + CW'(1);
            end
            if (pose_on) begin
              if (sub_q == SUB_W'(STRIDE - 1)) begin
                sub_q <= '0;
                pch_q <= pch_q + CH_W'(1);
              end else begin
                sub_q <= sub_q + SUB_W'(1);
              end
            end
            if (ram_we) begin
              wa_q <= wa_q + AW'(1);
            end
          end
          default: ;
        endcase
      end
      if (rd_issue) begin
        rd_addr_q <= rd_addr_q + AW'(1);
        if (rd_ax_q == AX_W'(AXES - 1)) begin
          rd_ax_q <= '0;
          rd_ch_q <= rd_ch_q + CH_W'(1);
        end else begin
          rd_ax_q <= rd_ax_q + AX_W'(1);
        end
      end
      if (rd_issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // byte assembly and output tags
  always_ff @(posedge clk_i) begin
    if (in_fire && state_q == S_PAYLOAD && pose_on && in_word && lane != 2'd3) begin
      asm_q <= {rx_byte_i, asm_q[ASM_W-1:BYTE_W]};
    end
    if (rd_issue) begin
      out_ch_q   <= rd_ch_q;
      out_ax_q   <= rd_ax_q;
      out_last_q <= rd_last;
    end
  end

  tfd_pose_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_pose_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa_q),
    .wdata_i (ram_wdata),
    .re_i    (rd_issue),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign channel_o     = out_ch_q;
  assign axis_o        = out_ax_q;
  assign pose_value_o  = ram_rdata;
  assign last_of_run_o = out_last_q;

  a_rd_ch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (rd_ch_q <= last_ch_q))
    else $error("readout channel ran past the last selected channel");

  a_last_ch_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (last_ch_q < CH_W'(CHANNELS)))
    else $error("readout range beyond the configured channels");

  a_emit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_issue && rd_last) |=> (state_q == S_HUNT))
    else $error("readout did not return to hunting after the last word");

  a_emit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EMIT) ##1 (state_q == S_EMIT) |-> (rd_ax_q == '0))
    else $error("readout did not start at the first axis");

endmodule

FILE: tb/tb_tracker_frame_deframer.sv
// tb_tracker_frame_deframer: self-checking bench for the tracker frame deframer.
// Feeds good and corrupted tracker frames, predicts every pose word and compares.
// Depends on tfd_pkg and tracker_frame_deframer.
`timescale 1ns / 1ps

module tb_tracker_frame_deframer
  import tfd_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 1500;
  localparam logic [ID_LEN*BYTE_W-1:0] ID_SEQ = 32'h0202_00C0;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic [AX_W-1:0]          ax;
    logic signed [POSE_W-1:0] val;
    logic                     last_run;
  } pose_word_t;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_HDR,
    FRAME_BAD_ID,
    FRAME_BAD_TAIL_FIRST,
    FRAME_BAD_TAIL_SECOND
  } frame_kind_e;

  typedef enum {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_EXTREME
  } fill_e;

  // Frame parser copy plus the queue of pose words still owed by the block.
  class pose_scoreboard;
    pose_word_t        pending_words[$];
    logic [MODE_W-1:0] mode;
    parse_state_e      phase;
    int unsigned       count;
    bit                tail_ok;
    bit                id_bad;
    logic [POSE_W-1:0] pose_mem [CHANNELS_DEF*AXES_DEF];
    int unsigned       errors, words_checked, words_predicted;
    int unsigned       frames_good, frames_dropped;

    function new();
      mode = '0;
      phase = S_HUNT;
      count = 0;
      tail_ok = 0;
      id_bad = 0;
      foreach (pose_mem[i]) pose_mem[i] = '0;
    endfunction

    function void note_byte(input logic [BYTE_W-1:0] b);
      int unsigned start, rel, first_ch, last_ch;
      bit emit;
      pose_word_t w;
      case (phase)
        S_HUNT: begin
          if (b == HDR_FIRST) phase = S_HDR2;
        end
        S_HDR2: begin
          // a wrong second byte is swallowed, even if it is A5
          if (b == HDR_SECOND) begin
            phase = S_ID;
            count = 0;
            id_bad = 0;
          end else begin
            phase = S_HUNT;
          end
        end
        S_ID: begin
          if (b != ID_SEQ[ID_LEN*BYTE_W-1-BYTE_W*count -: BYTE_W]) id_bad = 1;
          count++;
          if (count >= ID_LEN) begin
            count = 0;
            tail_ok = 0;
            phase = id_bad ? S_HUNT : S_PAYLOAD;
            if (id_bad) frames_dropped++;
          end
        end
        default: begin
          for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
            start = POSE_BASE + STRIDE*ch;
            if (count >= start && count - start < WORD_BYTES*AXES_DEF) begin
              rel = count - start;
              pose_mem[ch*AXES_DEF + rel/WORD_BYTES][BYTE_W*(rel%WORD_BYTES) +: BYTE_W] = b;
            end
          end
          if (count == PAYLOAD_BYTES_DEF - 2) tail_ok = (b == TAIL_FIRST);
          if (count >= PAYLOAD_BYTES_DEF - 1) begin
            if (tail_ok && b == TAIL_SECOND) begin
              frames_good++;
              emit = 1;
              if (mode == MODE_ALL) begin
                first_ch = 0;
                last_ch = CHANNELS_DEF - 1;
              end else if (mode < CHANNELS_DEF) begin
                first_ch = mode;
                last_ch = mode;
              end else begin
                emit = 0;
              end
              if (emit) begin
                for (int ch = first_ch; ch <= last_ch; ch++) begin
                  for (int ax = 0; ax < AXES_DEF; ax++) begin
                    w.ch = CH_W'(ch);
                    w.ax = AX_W'(ax);
                    w.val = pose_mem[ch*AXES_DEF + ax];
                    w.last_run = (ch == last_ch && ax == AXES_DEF - 1);
                    pending_words.insert(pending_words.size(), w);
                    words_predicted++;
                  end
                end
              end
            end else begin
              frames_dropped++;
            end
            phase = S_HUNT;
            count = 0;
            tail_ok = 0;
          end else begin
            count++;
          end
        end
      endcase
    endfunction

    function void check_field(input string name, input longint exp_v, input longint got_v);
      if (exp_v != got_v) begin
        $display("%0t: %0s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(input logic [CH_W-1:0] ch, input logic [AX_W-1:0] ax,
                             input logic signed [POSE_W-1:0] val, input logic last_run);
      pose_word_t w;
      if (pending_words.size() == 0) begin
        $display("%0t: pose word with no request pending, expected none, actual ch %0d ax %0d val %0d",
                 $time, ch, ax, val);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      words_checked++;
      check_field("channel", w.ch, ch);
      check_field("axis", w.ax, ax);
      check_field("pose_value", longint'(w.val), longint'(val));
      check_field("last_of_run", w.last_run, last_run);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [MODE_W-1:0]        cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [BYTE_W-1:0]        rx_byte_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [CH_W-1:0]          channel_o;
  logic [AX_W-1:0]          axis_o;
  logic signed [POSE_W-1:0] pose_value_o;
  logic                     last_of_run_o;

  pose_scoreboard sb = new();
  bit             idle_en = 1'b1;
  int unsigned    hold_cycles = 0;
  int unsigned    stall_left = 0;
  int unsigned    cycle_cnt = 0;
  int unsigned    bytes_sent = 0;
  bit [7:0]       modes_seen = '0;

  logic [BYTE_W-1:0] probe_bytes [20] = '{
    8'h00, 8'hFF,
    HDR_FIRST, HDR_FIRST, HDR_SECOND,                // second header byte A5 is swallowed
    HDR_FIRST, HDR_SECOND, 8'h02, 8'h02, 8'h00, 8'hC1,  // last ID byte off
    HDR_FIRST, HDR_SECOND, 8'h03, 8'h02, 8'h00, 8'hC0,  // first ID byte off
    HDR_FIRST, 8'h00, HDR_SECOND
  };

  logic [MODE_W-1:0] mode_plan [2] = '{MODE_ALL, 3'd3};

  tracker_frame_deframer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .channel_o    (channel_o),
    .axis_o       (axis_o),
    .pose_value_o (pose_value_o),
    .last_of_run_o(last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: checks words, stalls in bursts, and holds off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_word(channel_o, axis_o, pose_value_o, last_of_run_o);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_kind_e kind, input fill_e fill);
    logic [BYTE_W-1:0] b, flip;
    logic [POSE_W-1:0] word;
    int unsigned bad_pos, start, rel;
    flip = BYTE_W'($urandom_range(1, 255));
    bad_pos = $urandom_range(0, ID_LEN - 1);
    send_byte(HDR_FIRST);
    if (kind == FRAME_BAD_HDR) begin
      b = BYTE_W'($urandom);
      if (b == HDR_SECOND) b = HDR_FIRST;
      send_byte(b);
      return;
    end
    send_byte(HDR_SECOND);
    for (int pos = 0; pos < ID_LEN; pos++)
      send_byte(ID_SEQ[ID_LEN*BYTE_W-1-BYTE_W*pos -: BYTE_W] ^
                ((kind == FRAME_BAD_ID && pos == bad_pos) ? flip : 8'h00));
    if (kind == FRAME_BAD_ID) return;
    for (int pos = 0; pos < PAYLOAD_BYTES_DEF - 2; pos++) begin
      b = BYTE_W'($urandom);
      for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
        start = POSE_BASE + STRIDE*ch;
        if (fill != FILL_RANDOM && pos >= start && pos < start + WORD_BYTES*AXES_DEF) begin
          rel = pos - start;
          case (fill)
            FILL_ZERO: word = '0;
            FILL_ONES: word = '1;
            default:   word = ((rel/WORD_BYTES) % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          endcase
          b = word[BYTE_W*(rel%WORD_BYTES) +: BYTE_W];
        end
      end
      send_byte(b);
    end
    send_byte(kind == FRAME_BAD_TAIL_FIRST ? TAIL_FIRST ^ flip : TAIL_FIRST);
    send_byte(kind == FRAME_BAD_TAIL_SECOND ? TAIL_SECOND ^ flip : TAIL_SECOND);
  endtask

  // sender goes quiet until every pose word is back and the readout is over
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.mode = m;
    modes_seen[m] = 1'b1;
  endtask

  initial begin
    logic [BYTE_W-1:0] b;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset mode: header and ID rejects only
    modes_seen[0] = 1'b1;
    foreach (probe_bytes[i]) send_byte(probe_bytes[i]);

    for (int p = 0; p < 2; p++) begin
      wait_idle();
      write_mode(mode_plan[p]);
      if (p == 1) idle_en = 1'b0;
      repeat ($urandom_range(0, 6)) begin
        b = BYTE_W'($urandom);
        if (b == HDR_FIRST) b = 8'h00;
        send_byte(b);
      end
      send_frame(FRAME_GOOD, p == 0 ? FILL_EXTREME : FILL_RANDOM);
      if (p == 0) begin
        // receiver holds off through the full readout while bytes keep coming
        hold_cycles = LONG_HOLD;
        send_frame(FRAME_BAD_ID, FILL_RANDOM);
      end
      while (sb.phase != S_HUNT) send_byte(8'h00);
    end

    wait_idle();
    $display("Run: %0d bytes, %0d good frames, %0d rejected frames, %0d pose words checked",
             bytes_sent, sb.frames_good, sb.frames_dropped, sb.words_checked);
    $display("channel_mode values used (bit per mode): %b", modes_seen);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
